// ===== hw/rtl/hflt_pkg.sv =====
package hflt_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int FS_W  = 24;
  localparam int ST_W  = 16;
  localparam int SC_W  = 11;
  localparam int IDX_W = 10;
  localparam int CFG_W = 24;

  localparam logic [FS_W-1:0] FIELD_STRENGTH_RST = 24'd327680;
  localparam logic [ST_W-1:0] STEP_TIME_RST      = 16'd3277;
  localparam logic [SC_W-1:0] SAMPLE_COUNT_RST   = 11'd200;
  localparam logic [SC_W-1:0] SAMPLE_MAX         = 11'd1024;

  typedef enum logic [1:0] {
    CFG_FIELD_STRENGTH = 2'd0,
    CFG_STEP_TIME      = 2'd1,
    CFG_SAMPLE_COUNT   = 2'd2
  } cfg_index_t;

  typedef enum logic {
    CMD_LAUNCH = 1'b0,
    CMD_STEP   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
  } hflt_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [IDX_W-1:0]   point_index;
    logic               final_point;
  } hflt_result_t;

  typedef enum logic [1:0] {
    OP_SQRT     = 2'd0,
    OP_DIV_NORM = 2'd1,
    OP_DIV_K    = 2'd2
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EMIT,
    S_D2_MUL,
    S_D2_ACC,
    S_NRM_SHIFT,
    S_NRM_MUL,
    S_NRM_ACC,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_NRM_CHECK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_K_GO,
    S_K_WAIT,
    S_KDT_MUL,
    S_KDT_ACC,
    S_W_MUL,
    S_W_ACC,
    S_POS_MUL,
    S_POS_ACC
  } state_t;

  typedef enum logic [1:0] {
    NRM_AIM  = 2'd0,
    NRM_DIST = 2'd1,
    NRM_VEL  = 2'd2
  } nrm_sel_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // quotient register: normalize divide needs 31+F bits, force divide 8+3F
  function automatic int quo_width(input int f);
    return imax(31 + f, 8 + 3 * f);
  endfunction

  function automatic int src_width(input int f);
    return imax(quo_width(f), 64);
  endfunction

endpackage

// ===== hw/rtl/hflt_iter.sv =====
module hflt_iter import hflt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  iter_ctl_t                          ctl,
  input  logic [src_width(FRAC_BITS)-1:0]    num,
  input  logic [63:0]                        den,
  output logic                               done,
  output logic [quo_width(FRAC_BITS)-1:0]    quo
);

  localparam int QW   = quo_width(FRAC_BITS);
  localparam int SRCW = src_width(FRAC_BITS);
  localparam int CNTW = $clog2(QW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  iter_op_t        op;
  logic [SRCW-1:0] src;
  logic [63:0]     acc;
  logic [63:0]     den_r;
  logic [CNTW-1:0] steps;
  logic [65:0]     opa;
  logic [65:0]     opb;
  logic [65:0]     diff;
  logic            ge;

  always_comb begin
    case (ctl.op)
      OP_SQRT:     steps = CNTW'(31);
      OP_DIV_NORM: steps = CNTW'(30 + FRAC_BITS);
      OP_DIV_K:    steps = CNTW'(7 + 3 * FRAC_BITS);
      default:     steps = CNTW'(31);
    endcase
  end

  // one shift-subtract step: restoring divide or digit-by-digit square root
  always_comb begin
    if (op == OP_SQRT) begin
      opa = {acc, src[SRCW-1], src[SRCW-2]};
      opb = {32'd0, quo[31:0], 2'b01};
    end else begin
      opa = {1'b0, acc, src[SRCW-1]};
      opb = {2'b00, den_r};
    end
    ge   = (opa >= opb);
    diff = opa - opb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        cnt   <= steps;
        op    <= ctl.op;
        src   <= num;
        den_r <= den;
        acc   <= '0;
        quo   <= '0;
      end else if (busy) begin
        acc <= ge ? diff[63:0] : opa[63:0];
        quo <= {quo[QW-2:0], ge};
        src <= (op == OP_SQRT) ? (src << 2) : (src << 1);
        cnt <= cnt - CNTW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/homing_field_line_tracer.sv =====
// Homing path tracer. A launch word (cmd 0) loads start, goal and the aim
// direction, normalized to unit length; a step word (cmd 1) emits the current
// point and then advances the path. The time is set by one shared
// shift-subtract unit: per normalize one 32-step square root and three
// (31+FRAC_BITS)-step divides, two normalizes per step, plus one
// (8+3*FRAC_BITS)-step force divide; one shared multiplier handles the products.
// A step word that emits the last point of the path does not advance it; one
// that comes with no path loaded emits nothing.
// A point can wait in the output register while the next path step is computed.
module homing_field_line_tracer import hflt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  hflt_item_t   item,
  output logic         result_valid,
  input  logic         result_stall,
  output hflt_result_t result,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int NW   = imax(imax(CW + 1, 32), F + 16);
  localparam int UW   = F + 2;
  localparam int VW   = F + 4;
  localparam int KW   = F + 15;
  localparam int KDW  = F + 14;
  localparam int MW   = imax(32, KW);
  localparam int QW   = quo_width(F);
  localparam int SRCW = src_width(F);
  localparam int SATW = imax(imax(CW, F + 1) + 2, 33);

  localparam logic [63:0] EPS2 = ((64'd1 << (2 * F)) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] EPS_LEN64 = ((64'd1 << F) + 64'd999999) / 64'd1000000;
  localparam logic [31:0] EPS_LEN = EPS_LEN64[31:0];
  localparam logic [QW-1:0] K_CAP_Q = QW'(1) << (F + 14);
  localparam logic [KW-1:0] K_CAP   = KW'(1) << (F + 14);
  localparam logic signed [SATW-1:0] CW_HI  = {{(SATW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SATW-1:0] CW_LO  = ~CW_HI;
  localparam logic signed [SATW-1:0] O32_HI = {{(SATW-31){1'b0}}, 31'h7FFF_FFFF};
  localparam logic signed [SATW-1:0] O32_LO = ~O32_HI;

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [SATW-1:0] v);
    if (v > CW_HI) return CW_HI[CW-1:0];
    if (v < CW_LO) return CW_LO[CW-1:0];
    return v[CW-1:0];
  endfunction

  function automatic logic signed [31:0] sat_32(input logic signed [SATW-1:0] v);
    if (v > O32_HI) return 32'sh7FFF_FFFF;
    if (v < O32_LO) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [NW-1:0] mag_nw(input logic signed [NW-1:0] v);
    return v[NW-1] ? NW'(-v) : NW'(v);
  endfunction

  state_t state, state_next;

  logic [FS_W-1:0] field_strength;
  logic [ST_W-1:0] step_time;
  logic [SC_W-1:0] sample_count;

  logic signed [CW-1:0] position [3];
  logic signed [CW-1:0] target [3];
  logic signed [VW-1:0] velocity [3];
  logic signed [UW-1:0] u [3];
  logic [SC_W-1:0]      emitted_count;
  logic [SC_W-1:0]      limit;
  logic                 path_active;

  logic [NW-1:0]  nm [3];
  logic [2:0]     neg;
  logic           nshift;
  nrm_sel_t       nsel;
  logic [63:0]    nsum;
  logic [31:0]    nlen;
  logic [63:0]    d2;
  logic [KW-1:0]  k;
  logic [KDW-1:0] kdt;
  logic [1:0]     idx;

  logic [MW-1:0]   mul_a;
  logic [MW-1:0]   mul_b;
  logic [2*MW-1:0] prod;

  iter_ctl_t       ictl;
  logic [SRCW-1:0] inum;
  logic            idone;
  logic [QW-1:0]   iquo;

  logic [SC_W-1:0] lim_now;
  logic            step_ok;
  logic            out_free;
  logic            last_pt;
  logic            big;
  logic            short_vec;
  logic signed [NW-1:0] dvec [3];
  logic signed [NW-1:0] aimv [3];
  logic [64:0]     d2_sum;
  logic [63:0]     d2_term;
  logic [F:0]      qmag;
  logic signed [UW-1:0] qval;
  logic [F:0]      umag;
  logic [F:0]      vmag;
  logic [NW-1:0]   wt;
  logic signed [NW-1:0] wsum;
  logic [SATW-1:0] pt;
  logic signed [SATW-1:0] psum;

  hflt_iter #(.FRAC_BITS(F)) u_iter (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ictl),
    .num  (inum),
    .den  ((ictl.op == OP_DIV_K) ? d2 : {32'd0, nlen}),
    .done (idone),
    .quo  (iquo)
  );

  always_comb begin
    if (sample_count == '0) lim_now = SC_W'(1);
    else if (sample_count > SAMPLE_MAX) lim_now = SAMPLE_MAX;
    else lim_now = sample_count;
    step_ok  = path_active && (emitted_count < lim_now);
    out_free = !result_valid || !result_stall;
    last_pt  = (SC_W'(emitted_count + SC_W'(1)) >= limit);
    big      = (|(nm[0] >> 31)) || (|(nm[1] >> 31)) || (|(nm[2] >> 31));
    short_vec = (nlen == '0) || (!nshift && (nlen < EPS_LEN));
    for (int i = 0; i < 3; i++) begin
      dvec[i] = NW'(target[i]) - NW'(position[i]);
    end
    aimv[0] = NW'(item.aim_x);
    aimv[1] = NW'(item.aim_y);
    aimv[2] = NW'(item.aim_z);
    // component of 2^32 or more squares to all ones
    d2_term = (|(nm[idx] >> 32)) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
    d2_sum  = {1'b0, d2} + {1'b0, d2_term};
    qmag    = iquo[F:0];
    qval    = neg[idx] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    umag    = u[idx][UW-1] ? (F+1)'(-u[idx]) : (F+1)'(u[idx]);
    vmag    = velocity[idx][VW-1] ? (F+1)'(-velocity[idx]) : (F+1)'(velocity[idx]);
    wt      = NW'(prod >> F);
    wsum    = NW'(velocity[idx]) + (u[idx][UW-1] ? -$signed(wt) : $signed(wt));
    pt      = SATW'(prod >> 16);
    psum    = SATW'(position[idx]) + (velocity[idx][VW-1] ? -$signed(pt) : $signed(pt));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (item.cmd == CMD_LAUNCH) state_next = S_NRM_SHIFT;
          else if (step_ok) state_next = S_EMIT;
        end
      end
      S_EMIT:      if (out_free) state_next = last_pt ? S_IDLE : S_D2_MUL;
      S_D2_MUL:    state_next = S_D2_ACC;
      S_D2_ACC:    state_next = (idx == 2'd2) ? S_NRM_SHIFT : S_D2_MUL;
      S_NRM_SHIFT: if (!big) state_next = S_NRM_MUL;
      S_NRM_MUL:   state_next = S_NRM_ACC;
      S_NRM_ACC:   state_next = (idx == 2'd2) ? S_SQRT_GO : S_NRM_MUL;
      S_SQRT_GO:   state_next = S_SQRT_WAIT;
      S_SQRT_WAIT: if (idone) state_next = S_NRM_CHECK;
      S_NRM_CHECK, S_DIV_WAIT: begin
        if ((state == S_NRM_CHECK && short_vec) ||
            (state == S_DIV_WAIT && idone && idx == 2'd2)) begin
          case (nsel)
            NRM_AIM:  state_next = S_IDLE;
            NRM_DIST: state_next = S_K_GO;
            NRM_VEL:  state_next = S_POS_MUL;
            default:  state_next = S_IDLE;
          endcase
        end else if (state == S_NRM_CHECK || idone) begin
          state_next = S_DIV_GO;
        end
      end
      S_DIV_GO:    state_next = S_DIV_WAIT;
      S_K_GO:      state_next = S_K_WAIT;
      S_K_WAIT:    if (idone) state_next = S_KDT_MUL;
      S_KDT_MUL:   state_next = S_KDT_ACC;
      S_KDT_ACC:   state_next = S_W_MUL;
      S_W_MUL:     state_next = S_W_ACC;
      S_W_ACC:     state_next = (idx == 2'd2) ? S_NRM_SHIFT : S_W_MUL;
      S_POS_MUL:   state_next = S_POS_ACC;
      S_POS_ACC:   state_next = (idx == 2'd2) ? S_IDLE : S_POS_MUL;
      default:     state_next = S_IDLE;
    endcase
  end

  // outputs and shared unit controls
  always_comb begin
    item_stall = (state != S_IDLE);
    cfg_ready  = 1'b1;
    mul_a      = '0;
    mul_b      = '0;
    ictl.start = 1'b0;
    ictl.op    = OP_SQRT;
    inum       = SRCW'(nsum) << (SRCW - 64);
    case (state)
      S_D2_MUL: begin
        mul_a = MW'(nm[idx][31:0]);
        mul_b = MW'(nm[idx][31:0]);
      end
      S_NRM_MUL: begin
        mul_a = MW'(nm[idx][30:0]);
        mul_b = MW'(nm[idx][30:0]);
      end
      S_KDT_MUL: begin
        mul_a = MW'(k);
        mul_b = MW'(step_time);
      end
      S_W_MUL: begin
        mul_a = MW'(umag);
        mul_b = MW'(kdt);
      end
      S_POS_MUL: begin
        mul_a = MW'(vmag);
        mul_b = MW'(step_time);
      end
      S_SQRT_GO: begin
        ictl.start = 1'b1;
        ictl.op    = OP_SQRT;
      end
      S_DIV_GO: begin
        ictl.start = 1'b1;
        ictl.op    = OP_DIV_NORM;
        inum       = SRCW'(nm[idx][30:0]) << (SRCW - 31);
      end
      S_K_GO: begin
        ictl.start = 1'b1;
        ictl.op    = OP_DIV_K;
        inum       = SRCW'(field_strength) << (SRCW - FS_W);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      field_strength <= FIELD_STRENGTH_RST;
      step_time      <= STEP_TIME_RST;
      sample_count   <= SAMPLE_COUNT_RST;
      path_active    <= 1'b0;
      emitted_count  <= '0;
      result_valid   <= 1'b0;
      idx            <= '0;
      for (int i = 0; i < 3; i++) begin
        position[i] <= '0;
        target[i]   <= '0;
        velocity[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        case (cfg_index)
          CFG_FIELD_STRENGTH: field_strength <= cfg_data[FS_W-1:0];
          CFG_STEP_TIME:      step_time      <= cfg_data[ST_W-1:0];
          CFG_SAMPLE_COUNT:   sample_count   <= cfg_data[SC_W-1:0];
          default: begin
          end
        endcase
      end

      if (state == S_EMIT && out_free) result_valid <= 1'b1;
      else if (result_valid && !result_stall) result_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.cmd == CMD_LAUNCH) begin
              position[0] <= sat_cw(SATW'(item.start_x));
              position[1] <= sat_cw(SATW'(item.start_y));
              position[2] <= sat_cw(SATW'(item.start_z));
              target[0]   <= sat_cw(SATW'(item.goal_x));
              target[1]   <= sat_cw(SATW'(item.goal_y));
              target[2]   <= sat_cw(SATW'(item.goal_z));
              for (int i = 0; i < 3; i++) begin
                nm[i]  <= mag_nw(aimv[i]);
                neg[i] <= aimv[i][NW-1];
              end
              nshift        <= 1'b0;
              nsel          <= NRM_AIM;
              emitted_count <= '0;
              path_active   <= 1'b1;
            end else if (step_ok) begin
              limit <= lim_now;
            end else begin
              path_active <= 1'b0;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result.point_x     <= sat_32(SATW'(position[0]));
            result.point_y     <= sat_32(SATW'(position[1]));
            result.point_z     <= sat_32(SATW'(position[2]));
            result.point_index <= emitted_count[IDX_W-1:0];
            result.final_point <= (SC_W'(emitted_count + SC_W'(1)) == limit);
            emitted_count      <= emitted_count + SC_W'(1);
            if (last_pt) begin
              path_active <= 1'b0;
            end else begin
              for (int i = 0; i < 3; i++) begin
                nm[i]  <= mag_nw(dvec[i]);
                neg[i] <= dvec[i][NW-1];
              end
              d2     <= EPS2;
              idx    <= '0;
              nsel   <= NRM_DIST;
              nshift <= 1'b0;
            end
          end
        end
        S_D2_ACC: begin
          d2  <= d2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : d2_sum[63:0];
          idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        end
        S_NRM_SHIFT: begin
          if (big) begin
            for (int i = 0; i < 3; i++) nm[i] <= nm[i] >> 1;
            nshift <= 1'b1;
          end else begin
            idx  <= '0;
            nsum <= '0;
          end
        end
        S_NRM_ACC: begin
          nsum <= nsum + prod[63:0];
          idx  <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        end
        S_SQRT_WAIT: if (idone) nlen <= iquo[31:0];
        S_NRM_CHECK: begin
          if (short_vec) begin
            for (int i = 0; i < 3; i++) begin
              if (nsel == NRM_DIST) u[i] <= '0;
              else velocity[i] <= '0;
            end
          end
        end
        S_DIV_WAIT: begin
          if (idone) begin
            if (nsel == NRM_DIST) u[idx] <= qval;
            else velocity[idx] <= VW'(qval);
            idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
          end
        end
        S_K_WAIT: begin
          if (idone) k <= ((d2 == '0) || (iquo > K_CAP_Q)) ? K_CAP : iquo[KW-1:0];
        end
        S_KDT_ACC: begin
          kdt <= KDW'(prod >> 16);
          idx <= '0;
        end
        S_W_ACC: begin
          nm[idx]  <= mag_nw(wsum);
          neg[idx] <= wsum[NW-1];
          nshift   <= 1'b0;
          nsel     <= NRM_VEL;
          idx      <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        end
        S_POS_ACC: begin
          position[idx] <= sat_cw(psum);
          idx           <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
